// ===== design/vr2d_pkg.sv =====
// Shared types, constants and lookup tables for the 2D vector rotator.
package vr2d_pkg;

    localparam int CS_W       = 32;
    localparam int Z_W        = 32;
    localparam int FRAC_CS    = 30;
    localparam int ANGLE_W    = 16;
    localparam int MIN_STAGES = 8;
    localparam int MAX_STAGES = 24;

    typedef logic signed [CS_W-1:0] t_cs;
    typedef logic signed [Z_W-1:0]  t_z;
    typedef logic [1:0]             t_quad;
    typedef logic [ANGLE_W-1:0]     t_angle;

    localparam t_quad QUAD_0   = 2'd0;
    localparam t_quad QUAD_90  = 2'd1;
    localparam t_quad QUAD_180 = 2'd2;
    localparam t_quad QUAD_270 = 2'd3;

    typedef struct packed {
        t_cs   cx;
        t_cs   sy;
        t_z    z;
        t_quad quad;
    } t_rot;

    function automatic t_z atan_of(input int stage);
        t_z v;
        case (stage)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2F9;
            15:      v = 32'h0000517D;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A30;
            19:      v = 32'h00000518;
            20:      v = 32'h0000028C;
            21:      v = 32'h00000146;
            22:      v = 32'h000000A3;
            23:      v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic t_cs gain_of(input int stages);
        t_cs v;
        case (stages)
            8:       v = 32'sd652039507;
            9:       v = 32'sd652034532;
            10:      v = 32'sd652033289;
            11:      v = 32'sd652032978;
            12:      v = 32'sd652032900;
            13:      v = 32'sd652032881;
            14:      v = 32'sd652032876;
            default: v = 32'sd652032874;
        endcase
        return v;
    endfunction

endpackage

// ===== design/vr2d_if.sv =====
// Valid/ready channel interfaces for the rotator input points and results.
interface vr2d_in_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] in_x;
    logic signed [COORD_WIDTH-1:0] in_y;
    logic [15:0]                   angle;

    modport source (output valid, output in_x, output in_y, output angle, input ready);
    modport sink   (input valid, input in_x, input in_y, input angle, output ready);
endinterface

interface vr2d_out_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic                          saturated;

    modport source (output valid, output out_x, output out_y, output saturated, input ready);
    modport sink   (input valid, input out_x, input out_y, input saturated, output ready);
endinterface

// ===== design/vector_rotate_2d.sv =====
// Throughput: one point per cycle; the whole pipeline advances when the output
// register is empty or its result is taken, so input ready follows output ready.
// Stages: angle prep, one register per CORDIC cell, products, sums, round/saturate.
// Reset is synchronous and active low; it clears every stage valid flag only.
module vector_rotate_2d #(
    parameter int COORD_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    vr2d_in_if.sink        i_in,
    vr2d_out_if.source     o_out
);
    import vr2d_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int N   = CORDIC_STAGES;
    localparam int PW  = CS_W + W;
    localparam int SW  = PW + 1;
    localparam int RW  = SW - FRAC_CS;
    localparam logic signed [SW-1:0] RND = {{(SW - FRAC_CS + 1){1'b0}}, {(FRAC_CS - 1){1'b0}}}
                                           | (SW'(1) << (FRAC_CS - 1));
    localparam logic signed [RW-1:0] HI  = {{(RW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [RW-1:0] LO  = ~HI;

    logic   en;
    t_angle a_sum;
    t_quad  a_quad;
    t_angle a_resid;
    t_rot   n_prep;

    logic                  c_vld [N+1];
    t_rot                  c_rot [N+1];
    logic signed [W-1:0]   c_px  [N+1];
    logic signed [W-1:0]   c_py  [N+1];

    t_cs cos_v;
    t_cs sin_v;

    logic                  r_mul_vld;
    logic signed [PW-1:0]  r_p_cx;
    logic signed [PW-1:0]  r_p_sy;
    logic signed [PW-1:0]  r_p_sx;
    logic signed [PW-1:0]  r_p_cy;

    logic                  r_sum_vld;
    logic signed [SW-1:0]  r_sum_x;
    logic signed [SW-1:0]  r_sum_y;

    logic signed [SW-1:0]  rnd_x;
    logic signed [SW-1:0]  rnd_y;
    logic signed [RW-1:0]  rx;
    logic signed [RW-1:0]  ry;
    logic signed [W-1:0]   n_out_x;
    logic signed [W-1:0]   n_out_y;
    logic                  n_out_sat;

    logic                  r_out_vld;
    logic signed [W-1:0]   r_out_x;
    logic signed [W-1:0]   r_out_y;
    logic                  r_out_sat;

    logic                  r_prep_vld;
    t_rot                  r_prep_rot;
    logic signed [W-1:0]   r_prep_px;
    logic signed [W-1:0]   r_prep_py;

    assign en         = !r_out_vld || o_out.ready;
    assign i_in.ready = en;

    always_comb begin
        a_sum       = i_in.angle + 16'h2000;
        a_quad      = a_sum[ANGLE_W-1:ANGLE_W-2];
        a_resid     = i_in.angle - {a_quad, {(ANGLE_W - 2){1'b0}}};
        n_prep.quad = a_quad;
        n_prep.cx   = gain_of(N);
        n_prep.sy   = '0;
        n_prep.z    = {a_resid, {(Z_W - ANGLE_W){1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep_vld <= 1'b0;
            r_mul_vld  <= 1'b0;
            r_sum_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else if (en) begin
            r_prep_vld <= i_in.valid;
            r_mul_vld  <= c_vld[N];
            r_sum_vld  <= r_mul_vld;
            r_out_vld  <= r_sum_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prep_rot <= n_prep;
            r_prep_px  <= i_in.in_x;
            r_prep_py  <= i_in.in_y;
        end
    end

    assign c_vld[0] = r_prep_vld;
    assign c_rot[0] = r_prep_rot;
    assign c_px[0]  = r_prep_px;
    assign c_py[0]  = r_prep_py;

    for (genvar g = 0; g < N; g++) begin : g_cell
        vr2d_cell #(
            .STAGE       (g),
            .COORD_WIDTH (W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (c_vld[g]),
            .i_rot   (c_rot[g]),
            .i_px    (c_px[g]),
            .i_py    (c_py[g]),
            .o_vld   (c_vld[g+1]),
            .o_rot   (c_rot[g+1]),
            .o_px    (c_px[g+1]),
            .o_py    (c_py[g+1])
        );
    end

    always_comb begin
        case (c_rot[N].quad)
            QUAD_0: begin
                cos_v = c_rot[N].cx;
                sin_v = c_rot[N].sy;
            end
            QUAD_90: begin
                cos_v = -c_rot[N].sy;
                sin_v = c_rot[N].cx;
            end
            QUAD_180: begin
                cos_v = -c_rot[N].cx;
                sin_v = -c_rot[N].sy;
            end
            default: begin
                cos_v = c_rot[N].sy;
                sin_v = -c_rot[N].cx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_cx <= PW'(cos_v) * PW'(c_px[N]);
            r_p_sy <= PW'(sin_v) * PW'(c_py[N]);
            r_p_sx <= PW'(sin_v) * PW'(c_px[N]);
            r_p_cy <= PW'(cos_v) * PW'(c_py[N]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum_x <= SW'(r_p_cx) - SW'(r_p_sy);
            r_sum_y <= SW'(r_p_sx) + SW'(r_p_cy);
        end
    end

    always_comb begin
        rnd_x     = r_sum_x + RND;
        rnd_y     = r_sum_y + RND;
        rx        = rnd_x[SW-1:FRAC_CS];
        ry        = rnd_y[SW-1:FRAC_CS];
        n_out_sat = 1'b0;
        if (rx > HI) begin
            n_out_x   = HI[W-1:0];
            n_out_sat = 1'b1;
        end else if (rx < LO) begin
            n_out_x   = LO[W-1:0];
            n_out_sat = 1'b1;
        end else begin
            n_out_x   = rx[W-1:0];
        end
        if (ry > HI) begin
            n_out_y   = HI[W-1:0];
            n_out_sat = 1'b1;
        end else if (ry < LO) begin
            n_out_y   = LO[W-1:0];
            n_out_sat = 1'b1;
        end else begin
            n_out_y   = ry[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_x   <= n_out_x;
            r_out_y   <= n_out_y;
            r_out_sat <= n_out_sat;
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.out_x     = r_out_x;
    assign o_out.out_y     = r_out_y;
    assign o_out.saturated = r_out_sat;

endmodule

// ===== design/vr2d_cell.sv =====
// One rotation-mode CORDIC cell: a single micro-rotation with its own register.
module vr2d_cell #(
    parameter int STAGE       = 0,
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  vr2d_pkg::t_rot                i_rot,
    input  logic signed [COORD_WIDTH-1:0] i_px,
    input  logic signed [COORD_WIDTH-1:0] i_py,
    output logic                          o_vld,
    output vr2d_pkg::t_rot                o_rot,
    output logic signed [COORD_WIDTH-1:0] o_px,
    output logic signed [COORD_WIDTH-1:0] o_py
);
    import vr2d_pkg::*;

    localparam t_z ATAN = atan_of(STAGE);

    t_cs  cx;
    t_cs  sy;
    t_cs  dx;
    t_cs  dy;
    t_rot n_rot;
    t_rot r_rot;
    logic r_vld;
    logic signed [COORD_WIDTH-1:0] r_px;
    logic signed [COORD_WIDTH-1:0] r_py;

    always_comb begin
        cx = i_rot.cx;
        sy = i_rot.sy;
        dx = sy >>> STAGE;
        dy = cx >>> STAGE;
        n_rot.quad = i_rot.quad;
        if (!i_rot.z[Z_W-1]) begin
            n_rot.cx = cx - dx;
            n_rot.sy = sy + dy;
            n_rot.z  = i_rot.z - ATAN;
        end else begin
            n_rot.cx = cx + dx;
            n_rot.sy = sy - dy;
            n_rot.z  = i_rot.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot <= n_rot;
            r_px  <= i_px;
            r_py  <= i_py;
        end
    end

    assign o_vld = r_vld;
    assign o_rot = r_rot;
    assign o_px  = r_px;
    assign o_py  = r_py;

endmodule

// ===== design/vr2d_check.sv =====
// Port-level assertion checker for the 2D vector rotator, bound to the top level.
module vr2d_check #(
    parameter int COORD_WIDTH = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic signed [COORD_WIDTH-1:0] i_out_x,
    input logic signed [COORD_WIDTH-1:0] i_out_y,
    input logic                          i_out_sat
);
    localparam logic signed [COORD_WIDTH-1:0] MAX_V = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] MIN_V = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

    // A stalled result stays valid.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_x) && $stable(i_out_y)
                                        && $stable(i_out_sat))
        else $error("result changed while stalled");

    // With no result waiting, the pipeline must accept new points.
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input not ready with empty output register");

    // A saturated result shows a clipped coordinate.
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_sat |-> i_out_x == MAX_V || i_out_x == MIN_V
                                     || i_out_y == MAX_V || i_out_y == MIN_V)
        else $error("saturation flag without a clipped coordinate");

    // Leaving reset, no result is pending.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind vector_rotate_2d vr2d_check #(
    .COORD_WIDTH (COORD_WIDTH)
) u_vr2d_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_x     (o_out.out_x),
    .i_out_y     (o_out.out_y),
    .i_out_sat   (o_out.saturated)
);
